[rtl/vlr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlr_pkg: shared types and constants of the 3D voxel line rasteriser
// Field widths, axis codes and the control and status words that pass
// between the sequencer and the stepping unit.
// ----------------------------------------------------------------------------
package vlr_pkg;

    localparam int COORD_W      = 26;
    localparam int DELTA_W      = COORD_W + 1;
    localparam int BLOCK_W      = 8;
    localparam int NUM_AXES     = 3;
    localparam int MAX_SPAN_DEF = 63;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic [BLOCK_W-1:0]        t_block;

    typedef logic [1:0] t_axis;
    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
    } t_line;

    // Commands from the sequencer to the stepping unit, at most one per cycle.
    typedef struct packed {
        logic load;
        logic absval;
        logic setup;
        logic step;
    } t_dda_cmd;

    typedef struct packed {
        logic span_zero;
        logic span_over;
        logic last;
    } t_dda_stat;

endpackage

[rtl/vlr_interfaces.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlr interfaces: handshake channels of the voxel line rasteriser
// Line words in, voxel words out, and the fill block register write channel.
// ----------------------------------------------------------------------------
interface vlr_line_if import vlr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord start_x;
    t_coord start_y;
    t_coord start_z;
    t_coord end_x;
    t_coord end_y;
    t_coord end_z;

    modport source (output valid, output start_x, output start_y, output start_z,
                    output end_x, output end_y, output end_z, input ready);
    modport sink   (input valid, input start_x, input start_y, input start_z,
                    input end_x, input end_y, input end_z, output ready);
endinterface

interface vlr_voxel_if import vlr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord voxel_x;
    t_coord voxel_y;
    t_coord voxel_z;
    t_block voxel_block;
    logic   span_error;
    logic   last_voxel;

    modport source (output valid, output voxel_x, output voxel_y, output voxel_z,
                    output voxel_block, output span_error, output last_voxel,
                    input ready);
    modport sink   (input valid, input voxel_x, input voxel_y, input voxel_z,
                    input voxel_block, input span_error, input last_voxel,
                    output ready);
endinterface

interface vlr_cfg_if import vlr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_block data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/vlr_dda_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlr_dda_unit: line set-up and per-voxel stepping unit
// Holds the current voxel, finds the major axis and span, and advances all
// three coordinates by one major step per step command using exact
// remainder tracking for the minor axes.
// ----------------------------------------------------------------------------
module vlr_dda_unit import vlr_pkg::*; #(
    parameter int MAX_SPAN = MAX_SPAN_DEF
) (
    input  logic      i_clk,
    input  t_dda_cmd  i_cmd,
    input  t_line     i_line,
    output t_coord    o_voxel_x,
    output t_coord    o_voxel_y,
    output t_coord    o_voxel_z,
    output t_dda_stat o_stat
);

    localparam int SPAN_W = $clog2(MAX_SPAN + 1);
    // The remainder lives in [-2D, 4D) between add and correction.
    localparam int RW     = SPAN_W + 3;

    t_coord                r_coord [NUM_AXES];
    t_delta                r_delta [NUM_AXES];
    logic [DELTA_W-1:0]    r_abs   [NUM_AXES];
    logic signed [RW-1:0]  r_rem   [NUM_AXES];
    logic signed [RW-1:0]  r_d2    [NUM_AXES];
    logic [SPAN_W-1:0]     r_span;
    logic [SPAN_W-1:0]     r_k;
    t_axis                 r_major;
    logic                  r_neg;
    logic                  r_span_zero;
    logic                  r_span_over;

    t_axis                 maj01;
    logic [DELTA_W-1:0]    big01;
    t_axis                 maj;
    logic [DELTA_W-1:0]    span_full;
    logic signed [RW-1:0]  span2;
    logic signed [RW-1:0]  sum     [NUM_AXES];
    t_coord                n_coord [NUM_AXES];
    logic signed [RW-1:0]  n_rem   [NUM_AXES];

    // Major axis: the first one with the largest absolute delta, so ties go to the lower axis.
    always_comb begin
        if (r_abs[1] > r_abs[0]) begin
            maj01 = AXIS_Y;
            big01 = r_abs[1];
        end else begin
            maj01 = AXIS_X;
            big01 = r_abs[0];
        end
        if (r_abs[2] > big01) begin
            maj       = AXIS_Z;
            span_full = r_abs[2];
        end else begin
            maj       = maj01;
            span_full = big01;
        end
    end

    assign span2 = {2'b00, r_span, 1'b0};

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            sum[a] = r_rem[a] + r_d2[a];
            if (t_axis'(a) == r_major) begin
                n_coord[a] = r_coord[a] + (r_neg ? t_coord'(-1) : t_coord'(1));
                n_rem[a]   = r_rem[a];
            end else if (sum[a] >= span2) begin
                n_coord[a] = r_coord[a] + t_coord'(1);
                n_rem[a]   = sum[a] - span2;
            end else if (sum[a] < 0) begin
                n_coord[a] = r_coord[a] - t_coord'(1);
                n_rem[a]   = sum[a] + span2;
            end else begin
                n_coord[a] = r_coord[a];
                n_rem[a]   = sum[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_coord[0] <= i_line.start_x;
            r_coord[1] <= i_line.start_y;
            r_coord[2] <= i_line.start_z;
            r_delta[0] <= {i_line.end_x[COORD_W-1], i_line.end_x}
                          - {i_line.start_x[COORD_W-1], i_line.start_x};
            r_delta[1] <= {i_line.end_y[COORD_W-1], i_line.end_y}
                          - {i_line.start_y[COORD_W-1], i_line.start_y};
            r_delta[2] <= {i_line.end_z[COORD_W-1], i_line.end_z}
                          - {i_line.start_z[COORD_W-1], i_line.start_z};
        end
        if (i_cmd.absval) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_abs[a] <= r_delta[a][DELTA_W-1] ? DELTA_W'(-r_delta[a])
                                                  : DELTA_W'(r_delta[a]);
            end
        end
        if (i_cmd.setup) begin
            r_major     <= maj;
            r_neg       <= r_delta[maj][DELTA_W-1];
            r_span      <= span_full[SPAN_W-1:0];
            r_k         <= '0;
            r_span_zero <= (span_full == '0);
            r_span_over <= (span_full > DELTA_W'(MAX_SPAN));
            // Start at k = 0: numerator D over denominator 2D.
            for (int a = 0; a < NUM_AXES; a++) begin
                r_rem[a] <= {3'b000, span_full[SPAN_W-1:0]};
                r_d2[a]  <= {r_delta[a][RW-2:0], 1'b0};
            end
        end
        if (i_cmd.step) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_coord[a] <= n_coord[a];
                r_rem[a]   <= n_rem[a];
            end
            r_k <= r_k + SPAN_W'(1);
        end
    end

    assign o_voxel_x        = r_coord[0];
    assign o_voxel_y        = r_coord[1];
    assign o_voxel_z        = r_coord[2];
    assign o_stat.span_zero = r_span_zero;
    assign o_stat.span_over = r_span_over;
    assign o_stat.last      = (r_k == r_span);

endmodule

[rtl/voxel_line_rasterizer_3d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_line_rasterizer_3d: 3D line to voxel rasteriser
// Emits one voxel word per major-axis position from start to end point inclusive, each
// stamped with the fill block register.
//
//   channel   dir  handshake        word
//   i_line    in   valid / ready    start and end point, 26-bit signed each
//   o_voxel   out  valid / ready    voxel position, block, error, last flag
//   i_cfg     in   valid / ready    fill block identifier, 8 bits
//
// A line is accepted in S_IDLE, which forms the deltas, then passes S_ABS, S_AXIS
// and S_CHECK for absolute deltas, major axis selection and span check, then the
// stepping unit yields one voxel per cycle while the output register is free. A
// zero-length line emits nothing; an over-long line emits a single error word.
// Reset is synchronous and active low and clears the sequencer, output valid and
// fill register. The output register stalls the stepping unit while its word is
// not taken.
// ----------------------------------------------------------------------------
module voxel_line_rasterizer_3d import vlr_pkg::*; #(
    parameter int MAX_SPAN = MAX_SPAN_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vlr_line_if.sink     i_line,
    vlr_voxel_if.source  o_voxel,
    vlr_cfg_if.sink      i_cfg
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ABS   = 6'b000010,
        S_AXIS  = 6'b000100,
        S_CHECK = 6'b001000,
        S_RUN   = 6'b010000,
        S_ERR   = 6'b100000
    } t_state;

    t_state    r_state, n_state;
    t_block    r_fill;
    logic      r_out_valid;
    t_coord    r_out_x, r_out_y, r_out_z;
    t_block    r_out_block;
    logic      r_out_error, r_out_last;

    t_dda_cmd  cmd;
    t_dda_stat stat;
    t_line     line;
    t_coord    cur_x, cur_y, cur_z;
    logic      out_free;
    logic      load_voxel, load_error;

    assign line.start_x = i_line.start_x;
    assign line.start_y = i_line.start_y;
    assign line.start_z = i_line.start_z;
    assign line.end_x   = i_line.end_x;
    assign line.end_y   = i_line.end_y;
    assign line.end_z   = i_line.end_z;

    vlr_dda_unit #(
        .MAX_SPAN (MAX_SPAN)
    ) u_dda (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_line    (line),
        .o_voxel_x (cur_x),
        .o_voxel_y (cur_y),
        .o_voxel_z (cur_z),
        .o_stat    (stat)
    );

    assign out_free   = !r_out_valid || o_voxel.ready;
    assign load_voxel = (r_state == S_RUN) && out_free;
    assign load_error = (r_state == S_ERR) && out_free;

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_line.valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_ABS;
                end
            end
            S_ABS: begin
                cmd.absval = 1'b1;
                n_state    = S_AXIS;
            end
            S_AXIS: begin
                cmd.setup = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (stat.span_zero) begin
                    n_state = S_IDLE;
                end else if (stat.span_over) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (out_free) begin
                    cmd.step = 1'b1;
                    if (stat.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_fill <= i_cfg.data;
            end
            if (load_voxel || load_error) begin
                r_out_valid <= 1'b1;
            end else if (o_voxel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word register; an error word carries zero position and block.
    always_ff @(posedge i_clk) begin
        if (load_voxel) begin
            r_out_x     <= cur_x;
            r_out_y     <= cur_y;
            r_out_z     <= cur_z;
            r_out_block <= r_fill;
            r_out_error <= 1'b0;
            r_out_last  <= stat.last;
        end else if (load_error) begin
            r_out_x     <= '0;
            r_out_y     <= '0;
            r_out_z     <= '0;
            r_out_block <= '0;
            r_out_error <= 1'b1;
            r_out_last  <= 1'b1;
        end
    end

    assign i_line.ready        = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_voxel.valid       = r_out_valid;
    assign o_voxel.voxel_x     = r_out_x;
    assign o_voxel.voxel_y     = r_out_y;
    assign o_voxel.voxel_z     = r_out_z;
    assign o_voxel.voxel_block = r_out_block;
    assign o_voxel.span_error  = r_out_error;
    assign o_voxel.last_voxel  = r_out_last;

endmodule

[bench/voxel_line_rasterizer_3d_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_line_rasterizer_3d_test: self-checking bench for the 3D line rasteriser
// Drives line words and fill block writes through the handshake channels.
// Each accepted line is expanded into its voxel words by an exact integer
// predictor, and every voxel word taken from the block is checked against
// the oldest expected word. The run covers directed corner lines and random
// lines over several fill values and several patterns of idling and stalls.
// ----------------------------------------------------------------------------
module voxel_line_rasterizer_3d_test;
    import vlr_pkg::*;

    localparam int  COORD_MAX    = (1 << (COORD_W - 1)) - 1;
    localparam int  COORD_MIN    = -(1 << (COORD_W - 1));
    localparam int  SPAN_LIMIT   = MAX_SPAN_DEF;
    localparam int  NUM_PHASES   = 6;
    localparam int  PHASE_LINES  = 26;
    localparam int  SETTLE_GAP   = 12;
    localparam int  DRAIN_GAP    = 80;
    localparam int  LIMIT_CYCLES = 400000;
    localparam int  REPORT_CAP   = 40;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        t_block blk;
        logic   err;
        logic   last;
    } t_voxel_word;

    logic clk;
    logic rst_n;

    vlr_line_if  line_ch ();
    vlr_voxel_if voxel_ch ();
    vlr_cfg_if   cfg_ch ();

    voxel_line_rasterizer_3d dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_line  (line_ch),
        .o_voxel (voxel_ch),
        .i_cfg   (cfg_ch)
    );

    t_line       pending_lines[$];
    t_voxel_word expected_voxels[$];
    t_block      fill_shadow;
    bit          line_fire;
    bit          cfg_fire;
    int          lines_pushed;
    int          lines_taken;
    int          mismatch_count;
    int          cycle_count;
    int          sender_idle_pct;
    int          recv_stall_pct;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // floor(n / d) for d > 0; the language's division truncates towards zero.
    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint abs_l(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Expands one line into the voxel words that it must produce.
    function automatic void predict_voxels(t_line ln);
        longint      s[3];
        longint      d[3];
        longint      span;
        longint      dir;
        longint      c;
        t_coord      pos[3];
        int          major;
        t_voxel_word w;
        s[0] = ln.start_x;
        s[1] = ln.start_y;
        s[2] = ln.start_z;
        d[0] = longint'(ln.end_x) - s[0];
        d[1] = longint'(ln.end_y) - s[1];
        d[2] = longint'(ln.end_z) - s[2];
        major = 0;
        for (int a = 1; a < NUM_AXES; a++) begin
            if (abs_l(d[a]) > abs_l(d[major]))
                major = a;
        end
        span = abs_l(d[major]);
        if (span == 0)
            return;
        if (span > SPAN_LIMIT) begin
            w = '{x: '0, y: '0, z: '0, blk: '0, err: 1'b1, last: 1'b1};
            expected_voxels.push_back(w);
            return;
        end
        dir = (d[major] > 0) ? 1 : -1;
        for (longint k = 0; k <= span; k++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                if (a == major)
                    c = s[a] + k * dir;
                else
                    c = s[a] + floor_div(2 * k * d[a] + span, 2 * span);
                pos[a] = t_coord'(c);
            end
            w = '{x: pos[0], y: pos[1], z: pos[2], blk: fill_shadow,
                  err: 1'b0, last: (k == span)};
            expected_voxels.push_back(w);
        end
    endfunction

    function automatic t_line make_random_line();
        t_line       ln;
        t_coord      sc[3];
        t_coord      ec[3];
        longint      dl[3];
        logic [31:0] r;
        int          kind;
        int          major;
        int          span;
        kind  = $urandom_range(99);
        major = $urandom_range(2);
        span  = 0;
        for (int a = 0; a < NUM_AXES; a++) begin
            r     = $urandom;
            sc[a] = r[COORD_W-1:0];
            dl[a] = 0;
        end
        if (kind < 80)
            span = ($urandom_range(3) == 0) ? $urandom_range(1, SPAN_LIMIT)
                                            : $urandom_range(1, 16);
        else if (kind < 88)
            span = $urandom_range(SPAN_LIMIT + 1, 1 << 20);
        if (span != 0) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                if (a == major)
                    dl[a] = $urandom_range(1) ? span : -span;
                else
                    dl[a] = longint'($urandom_range(0, 2 * span)) - span;
            end
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            r     = $urandom;
            ec[a] = (kind >= 93) ? t_coord'(r[COORD_W-1:0])
                                 : t_coord'(longint'(sc[a]) + dl[a]);
        end
        ln.start_x = sc[0];
        ln.start_y = sc[1];
        ln.start_z = sc[2];
        ln.end_x   = ec[0];
        ln.end_y   = ec[1];
        ln.end_z   = ec[2];
        return ln;
    endfunction

    task automatic push_line(input int sx, input int sy, input int sz,
                             input int ex, input int ey, input int ez);
        t_line ln;
        ln.start_x = t_coord'(sx);
        ln.start_y = t_coord'(sy);
        ln.start_z = t_coord'(sz);
        ln.end_x   = t_coord'(ex);
        ln.end_y   = t_coord'(ey);
        ln.end_z   = t_coord'(ez);
        pending_lines.push_back(ln);
        lines_pushed++;
    endtask

    task automatic write_fill(input t_block value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(negedge clk); while (!cfg_fire);
        cfg_ch.valid <= 1'b0;
    endtask

    // Line driver and receiver back-pressure, both moved at the falling edge.
    always @(negedge clk) begin
        t_line nxt;
        if (!(line_ch.valid && !line_fire)) begin
            if (rst_n && pending_lines.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
                nxt = pending_lines.pop_front();
                line_ch.valid   <= 1'b1;
                line_ch.start_x <= nxt.start_x;
                line_ch.start_y <= nxt.start_y;
                line_ch.start_z <= nxt.start_z;
                line_ch.end_x   <= nxt.end_x;
                line_ch.end_y   <= nxt.end_y;
                line_ch.end_z   <= nxt.end_z;
            end else begin
                line_ch.valid <= 1'b0;
            end
        end
        voxel_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: records handshakes, predicts on accepted lines, checks voxels.
    always @(posedge clk) begin
        t_voxel_word got;
        t_voxel_word want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
            $display("== FAIL ==");
            $finish;
        end else begin
            line_fire = rst_n && line_ch.valid && line_ch.ready;
            cfg_fire  = rst_n && cfg_ch.valid && cfg_ch.ready;
            if (cfg_fire)
                fill_shadow = cfg_ch.data;
            if (line_fire) begin
                lines_taken++;
                predict_voxels('{start_x: line_ch.start_x, start_y: line_ch.start_y,
                                 start_z: line_ch.start_z, end_x: line_ch.end_x,
                                 end_y: line_ch.end_y, end_z: line_ch.end_z});
            end
            if (rst_n && voxel_ch.valid && voxel_ch.ready) begin
                got = '{x: voxel_ch.voxel_x, y: voxel_ch.voxel_y, z: voxel_ch.voxel_z,
                        blk: voxel_ch.voxel_block, err: voxel_ch.span_error,
                        last: voxel_ch.last_voxel};
                if (expected_voxels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $display("%0t: unexpected word: expected none, ", $time,
                                 "got (%0d,%0d,%0d) blk=%0d err=%0b last=%0b",
                                 got.x, got.y, got.z, got.blk, got.err, got.last);
                end else begin
                    want = expected_voxels.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                        got.blk !== want.blk || got.err !== want.err ||
                        got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_CAP)
                            $display("%0t: voxel mismatch: ", $time,
                                     "expected (%0d,%0d,%0d) blk=%0d err=%0b last=%0b, ",
                                     want.x, want.y, want.z, want.blk, want.err,
                                     want.last,
                                     "got (%0d,%0d,%0d) blk=%0d err=%0b last=%0b",
                                     got.x, got.y, got.z, got.blk, got.err,
                                     got.last);
                    end
                end
            end
        end
    end

    initial begin
        int fill_plan[NUM_PHASES];
        int idle_plan[NUM_PHASES];
        int stall_plan[NUM_PHASES];
        clk             = 1'b0;
        rst_n           = 1'b0;
        line_ch.valid   = 1'b0;
        line_ch.start_x = '0;
        line_ch.start_y = '0;
        line_ch.start_z = '0;
        line_ch.end_x   = '0;
        line_ch.end_y   = '0;
        line_ch.end_z   = '0;
        voxel_ch.ready  = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        fill_shadow     = '0;
        line_fire       = 1'b0;
        cfg_fire        = 1'b0;
        lines_pushed    = 0;
        lines_taken     = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;

        // Phase 0 runs on the reset fill value; the rest write the register first.
        fill_plan  = '{-1, 255, $urandom_range(1, 254), 0, $urandom_range(255), 170};
        idle_plan  = '{0, 0, 52, 0, 14, 0};
        stall_plan = '{0, 0, 0, 52, 14, 0};

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (fill_plan[p] >= 0)
                write_fill(t_block'(fill_plan[p]));
            @(posedge clk);
            sender_idle_pct = idle_plan[p];
            recv_stall_pct  = stall_plan[p];
            if (p == 0) begin
                push_line(0, 0, 0, 0, 0, 0);
                push_line(0, 0, 0, 1, 0, 0);
                push_line(5, 5, 5, 5, 4, 5);
                push_line(-3, 7, 9, -3, 7, 10);
                // Exact halves round towards plus infinity on both signs.
                push_line(0, 0, 0, 2, 1, -1);
                push_line(0, 0, 0, 5, -5, 3);
                push_line(0, 0, 0, 1, 4, -4);
                push_line(10, 10, 10, 3, 3, 3);
                push_line(COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MIN + 63, COORD_MIN + 31, COORD_MIN + 62);
                push_line(0, COORD_MIN, 0, 1, COORD_MIN + 64, -2);
                push_line(COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX - 17, COORD_MAX - 40, COORD_MAX - 63);
                push_line(100, -100, 0, 90, -80, -64);
                push_line(COORD_MIN, 0, 0, COORD_MAX, 0, 0);
                push_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
                push_line(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
                push_line(1, 2, 3, 8, -5, 10);
                push_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
                push_line(0, 0, 0, 63, 1, -1);
                push_line(0, 0, 0, -63, 62, -62);
                push_line(0, COORD_MIN, 0, 0, COORD_MIN + 63, 0);
                push_line(-1, -1, -1, 0, 0, 0);
                push_line(7, 0, 0, 7, 0, -63);
            end else begin
                for (int i = 0; i < PHASE_LINES; i++) begin
                    pending_lines.push_back(make_random_line());
                    lines_pushed++;
                end
            end
            do @(negedge clk); while (lines_taken != lines_pushed || expected_voxels.size() != 0);
            // A zero-length line can still be in flight with nothing left to expect.
            repeat (SETTLE_GAP) @(negedge clk);
        end

        repeat (DRAIN_GAP) @(negedge clk);
        if (mismatch_count == 0 && expected_voxels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
